>>> src/les_pkg.sv
// les_pkg: shared types and constants of the line edit stack
// control bytes, sequencer state type and the result status struct
// no dependencies
package les_pkg;

   localparam logic [7:0] SYM_WORD_ERASE = 8'h40;
   localparam logic [7:0] SYM_CHAR_ERASE = 8'h2C;
   localparam logic [7:0] SYM_CLEAR      = 8'h21;
   localparam logic [7:0] SYM_STOP       = 8'h2E;
   localparam logic [7:0] SYM_SPACE      = 8'h20;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERASE_RD,
      ST_ERASE_CHK,
      ST_PRINT_RD,
      ST_OUT,
      ST_MARK
   } state_type;

   // flags that go with the result transaction on offer
   typedef struct packed {
      logic char_valid;
      logic print_last;
      logic overflow;
      logic line_done;
      logic nonempty;
   } status_type;

endpackage

>>> src/les_req_if.sv
// les_req_if: input channel of the line edit stack
// valid/ready handshake with one line byte and its line end flag
// no dependencies
interface les_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       line_end;

   modport source (output valid, output symbol, output line_end, input ready);
   modport sink   (input valid, input symbol, input line_end, output ready);
endinterface

>>> src/les_rsp_if.sv
// les_rsp_if: result channel of the line edit stack
// valid/ready handshake with one printed character and its flags
// no dependencies
interface les_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       char_valid;
   logic       print_last;
   logic       overflow;
   logic       line_done;
   logic       nonempty;

   modport source (output valid, output out_char, output char_valid, output print_last,
                   output overflow, output line_done, output nonempty, input ready);
   modport sink   (input valid, input out_char, input char_valid, input print_last,
                   input overflow, input line_done, input nonempty, output ready);
endinterface

>>> src/les_ram.sv
// les_ram: generic single write, single read RAM with registered read
// no dependencies
module les_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/les_seq.sv
// les_seq: sequencer of the line edit stack
// owns the stack pointer, the print index and the edit/print state machine
// depends on les_pkg
module les_seq #(
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [7:0]                              req_symbol,
   input  logic                                    req_line_end,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output les_pkg::status_type                     rsp_status,
   output logic                                    wr_en,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   output logic [7:0]                              wr_data,
   output logic                                    rd_en,
   output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   input  logic [7:0]                              rd_data
);
   import les_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type      state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  idx_ff, idx_in;
   logic           stopped_ff, stopped_in;
   logic           ovf_ff, ovf_in;
   logic           done_ff, done_in;

   logic           accept;
   logic           is_last;
   logic           rsp_take;

   assign accept   = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign is_last  = ((CW'(idx_ff) + CW'(1)) == count_ff);

   // stack pointer, flags and print index
   always_comb begin
      count_in   = count_ff;
      idx_in     = idx_ff;
      stopped_in = stopped_ff;
      ovf_in     = ovf_ff;
      done_in    = done_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               done_in = req_line_end;
               ovf_in  = 1'b0;
               if (!stopped_ff) begin
                  case (req_symbol)
                     SYM_WORD_ERASE: ;
                     SYM_CHAR_ERASE: begin
                        if (count_ff != '0) count_in = count_ff - CW'(1);
                     end
                     SYM_CLEAR: count_in = '0;
                     SYM_STOP:  stopped_in = 1'b1;
                     default: begin
                        if (count_ff != CW'(DEPTH)) count_in = count_ff + CW'(1);
                        else ovf_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_ERASE_CHK: begin
            if (rd_data != SYM_SPACE) count_in = count_ff - CW'(1);
         end
         ST_PRINT_RD: idx_in = '0;
         ST_OUT: begin
            if (rsp_take && !is_last) idx_in = idx_ff + AW'(1);
         end
         default: ;
      endcase
      // line end clears the buffer once the last result is taken
      if (rsp_take && done_ff && (state_ff == ST_MARK || is_last)) begin
         count_in   = '0;
         stopped_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (stopped_ff) begin
                  state_in = req_line_end ? ST_MARK : ST_IDLE;
               end else if (req_symbol == SYM_WORD_ERASE) begin
                  state_in = ST_ERASE_RD;
               end else begin
                  state_in = (count_in == '0) ? ST_MARK : ST_PRINT_RD;
               end
            end
         end
         ST_ERASE_RD:  state_in = (count_ff == '0) ? ST_MARK : ST_ERASE_CHK;
         ST_ERASE_CHK: state_in = (rd_data != SYM_SPACE) ? ST_ERASE_RD : ST_PRINT_RD;
         ST_PRINT_RD:  state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_take && is_last) state_in = ST_IDLE;
         end
         ST_MARK: begin
            if (rsp_take) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = req_symbol;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && !stopped_ff && count_ff != CW'(DEPTH)
                && req_symbol != SYM_WORD_ERASE && req_symbol != SYM_CHAR_ERASE
                && req_symbol != SYM_CLEAR && req_symbol != SYM_STOP) begin
               wr_en = 1'b1;
            end
         end
         ST_ERASE_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(count_ff - CW'(1));
         end
         ST_PRINT_RD: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            rd_en     = rsp_ready && !is_last;
            rd_addr   = idx_ff + AW'(1);
         end
         ST_MARK: rsp_valid = 1'b1;
         default: ;
      endcase
      rsp_status.char_valid = (state_ff == ST_OUT);
      rsp_status.print_last = (state_ff == ST_MARK) || is_last;
      rsp_status.overflow   = ovf_ff;
      rsp_status.line_done  = done_ff;
      rsp_status.nonempty   = done_ff && (count_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         stopped_ff <= 1'b0;
         ovf_ff     <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         stopped_ff <= stopped_in;
         ovf_ff     <= ovf_in;
         done_ff    <= done_in;
      end
      idx_ff <= idx_in;
   end
endmodule

>>> src/line_edit_stack_unit.sv
// line edit stack: one byte per input transaction, prints the buffer after each edit
// an empty result goes out from ST_MARK; a nonempty print reads entry 0 in ST_PRINT_RD, then ST_OUT
// word erase passes ST_ERASE_RD and ST_ERASE_CHK for each char it removes, and stops on the
// empty check or the space check; ready only in idle, so the next byte waits for the last result
// reset: stack pointer, stop flag and flags cleared; store contents undefined, no clear pass
// depends on les_pkg, les_req_if, les_rsp_if, les_ram, les_seq
module line_edit_stack_unit #(
   parameter int DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   les_req_if.sink     req_bus,
   les_rsp_if.source   rsp_bus
);
   import les_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // ram ports
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // flags of the result transaction on offer
   status_type    status;

   // character store, entry 0 is the oldest
   les_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // edit and print sequencer around the stack pointer
   les_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_bus.valid),
      .req_ready    (req_bus.ready),
      .req_symbol   (req_bus.symbol),
      .req_line_end (req_bus.line_end),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_status   (status),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data)
   );

   // empty marker carries a zero character
   assign rsp_bus.out_char   = status.char_valid ? rd_data : 8'h00;
   assign rsp_bus.char_valid = status.char_valid;
   assign rsp_bus.print_last = status.print_last;
   assign rsp_bus.overflow   = status.overflow;
   assign rsp_bus.line_done  = status.line_done;
   assign rsp_bus.nonempty   = status.nonempty;
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// testbench for line_edit_stack_unit: directed edit commands, a full buffer and random lines
// every printed result transaction is checked against a behavioral copy of the edit buffer
// depends on les_pkg, les_req_if, les_rsp_if and line_edit_stack_unit
module testbench;
   import les_pkg::*;

   localparam int DEPTH         = 32;
   // worst case: about 240 items of 32 results each, behind a receiver that mostly stalls
   localparam int CYCLE_LIMIT   = 600000;
   // word erase of a full buffer walks back character by character
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLDOFF_CYCLES = 400;

   // one printed result as the block should present it
   typedef struct packed {
      logic [7:0] out_char;
      status_type flags;
   } print_entry_type;

   logic clock;
   logic reset;

   les_req_if req_bus ();
   les_rsp_if rsp_bus ();

   line_edit_stack_unit #(
      .DEPTH (DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // behavioral copy of the edit buffer
   logic [7:0] line_chars [DEPTH];
   int         line_fill;
   bit         line_stopped;

   // prints still owed by the block, oldest first
   print_entry_type expected_prints [$];

   int error_count;
   int cycle_count;
   int printing_items;   // accepted items that caused at least one print
   int send_idle_pct;
   int recv_stall_pct;
   int holdoff_left;

   // free running clock, 10 ns period
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // edit buffer prediction
   // ---------------------------------------------------------------------------

   function automatic void queue_print(input logic [7:0] ch, input logic valid,
                                       input logic last, input logic ovf,
                                       input logic done, input logic ne);
      print_entry_type e;
      e.out_char         = ch;
      e.flags.char_valid = valid;
      e.flags.print_last = last;
      e.flags.overflow   = ovf;
      e.flags.line_done  = done;
      e.flags.nonempty   = ne;
      expected_prints.push_back(e);
   endfunction

   // apply one byte to the buffer, queue the prints it causes, return their number
   function automatic int edit_and_print(input logic [7:0] sym, input logic le);
      logic ovf;
      logic ne;
      int   n;
      ovf = 1'b0;
      n   = 0;
      // after a stop byte only the line end does anything
      if (line_stopped) begin
         if (!le)
            return 0;
         queue_print(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, line_fill != 0);
         line_fill    = 0;
         line_stopped = 1'b0;
         return 1;
      end
      case (sym)
         SYM_WORD_ERASE: begin
            // back to the nearest space, the space itself stays
            while (line_fill > 0 && line_chars[line_fill - 1] != SYM_SPACE)
               line_fill--;
         end
         SYM_CHAR_ERASE: begin
            if (line_fill > 0)
               line_fill--;
         end
         SYM_CLEAR: line_fill = 0;
         SYM_STOP:  line_stopped = 1'b1;
         default: begin
            if (line_fill < DEPTH) begin
               line_chars[line_fill] = sym;
               line_fill++;
            end else
               ovf = 1'b1;
         end
      endcase
      ne = le && (line_fill != 0);
      if (line_fill == 0) begin
         // empty buffer prints a single marker
         queue_print(8'h00, 1'b0, 1'b1, ovf, le, ne);
         n = 1;
      end else begin
         for (int i = 0; i < line_fill; i++)
            queue_print(line_chars[i], 1'b1, i + 1 == line_fill, ovf, le, ne);
         n = line_fill;
      end
      if (le) begin
         line_fill    = 0;
         line_stopped = 1'b0;
      end
      return n;
   endfunction

   // ---------------------------------------------------------------------------
   // input side: one transaction per call, starts and ends at a falling edge
   // ---------------------------------------------------------------------------

   task automatic send_item(input logic [7:0] sym, input logic le);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.symbol   = sym;
      req_bus.line_end = le;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      // accepted at this edge
      if (edit_and_print(sym, le) > 0)
         printing_items++;
      @(negedge clock);
   endtask

   // sender goes quiet until the block has printed everything and settled
   task automatic wait_drain();
      req_bus.valid = 1'b0;
      while (expected_prints.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------

   // receiver readiness: random stalls, or a counted holdoff when one is asked for
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_bus.ready = 1'b0;
         holdoff_left  = holdoff_left - 1;
      end else
         rsp_bus.ready = ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   task automatic check_flag(input string name, input logic want, input logic got);
      if (want !== got) begin
         $display("%0t: mismatch on %s, expected %0b, actual %0b", $time, name, want, got);
         error_count++;
      end
   endtask

   // compare each result transaction with the oldest owed print
   always @(posedge clock) begin
      print_entry_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_prints.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual char %0h valid %0b",
                     $time, rsp_bus.out_char, rsp_bus.char_valid);
            error_count++;
         end else begin
            want = expected_prints.pop_front();
            check_field("out_char",  want.out_char,         rsp_bus.out_char);
            check_flag("char_valid", want.flags.char_valid, rsp_bus.char_valid);
            check_flag("print_last", want.flags.print_last, rsp_bus.print_last);
            check_flag("overflow",   want.flags.overflow,   rsp_bus.overflow);
            check_flag("line_done",  want.flags.line_done,  rsp_bus.line_done);
            check_flag("nonempty",   want.flags.nonempty,   rsp_bus.nonempty);
         end
      end
   end

   // run time guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // mostly words and spaces, now and then an edit command or any byte at all
   function automatic logic [7:0] text_byte();
      int r;
      r = $urandom_range(99);
      if (r < 15)      return SYM_SPACE;
      else if (r < 68) return 8'(8'h61 + $urandom_range(25));
      else if (r < 78) return 8'($urandom_range(255));
      else if (r < 85) return SYM_WORD_ERASE;
      else if (r < 91) return SYM_CHAR_ERASE;
      else if (r < 94) return SYM_CLEAR;
      else if (r < 96) return SYM_STOP;
      else             return 8'(8'h41 + $urandom_range(25));
   endfunction

   // a well formed line: random content, line end on the last byte
   task automatic send_line(input int len);
      for (int i = 0; i < len; i++)
         send_item(text_byte(), i == len - 1);
   endtask

   // noise: any byte, line end at random
   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) send_item(8'($urandom_range(255)), $urandom_range(3) == 0);
   endtask

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------

   task automatic test_edit_commands();
      // erase on an empty buffer, both kinds, each giving the empty marker
      send_item(SYM_CHAR_ERASE, 1'b0);
      send_item(SYM_WORD_ERASE, 1'b0);
      // extreme bytes are plain text
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(SYM_SPACE, 1'b0);
      send_item(8'h61, 1'b0);
      send_item(8'h62, 1'b0);
      // word erase back to the space
      send_item(SYM_WORD_ERASE, 1'b0);
      // word erase on a trailing space leaves the buffer alone
      send_item(SYM_WORD_ERASE, 1'b0);
      send_item(SYM_CHAR_ERASE, 1'b0);
      // word erase with no space empties the buffer
      send_item(SYM_WORD_ERASE, 1'b0);
      send_item(8'h78, 1'b0);
      send_item(SYM_CLEAR, 1'b0);
      // line ends with and without buffered text
      send_item(8'h79, 1'b1);
      send_item(SYM_CLEAR, 1'b1);
      // stop byte, ignored bytes, then a line end that prints only the marker and drops the text
      send_item(8'h71, 1'b0);
      send_item(SYM_STOP, 1'b0);
      send_item(8'h7A, 1'b0);
      send_item(SYM_WORD_ERASE, 1'b0);
      send_item(8'h77, 1'b1);
      // stop byte on the line end itself
      send_item(8'h6B, 1'b0);
      send_item(SYM_STOP, 1'b1);
      // line end after a stop byte on an empty buffer, its byte ignored
      send_item(SYM_STOP, 1'b0);
      send_item(8'hFF, 1'b1);
      wait_drain();
   endtask

   task automatic test_full_buffer();
      for (int i = 0; i < DEPTH; i++)
         send_item(8'($urandom_range(255)) | 8'h80, 1'b0);
      // both pushes are dropped, the second also ends the line
      send_item(8'h7F, 1'b0);
      send_item(8'h00, 1'b1);
      wait_drain();
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_receiver_holdoff();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      holdoff_left   = HOLDOFF_CYCLES;
      send_line(12);
      send_line(6);
      wait_drain();
   endtask

   // sender pauses until every print is out, then carries on
   task automatic test_sender_pause();
      send_idle_pct  = 26;
      recv_stall_pct = 26;
      send_line(8);
      wait_drain();
      send_line(5);
      wait_drain();
   endtask

   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input int target);
      int start;
      int r;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start          = printing_items;
      while (printing_items - start < target) begin
         r = $urandom_range(99);
         if (r < 70)      send_line($urandom_range(1, 10));
         else if (r < 80) send_line($urandom_range(28, 40));
         else             send_noise();
      end
      wait_drain();
   endtask

   // ---------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.symbol   = 8'h00;
      req_bus.line_end = 1'b0;
      rsp_bus.ready    = 1'b0;
      error_count      = 0;
      cycle_count      = 0;
      printing_items   = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      holdoff_left     = 0;
      line_fill        = 0;
      line_stopped     = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_edit_commands();
      test_full_buffer();
      test_receiver_holdoff();
      test_sender_pause();
      // idling phases: none, sender only, receiver only, both
      test_random_phase(0, 0, 30);
      test_random_phase(73, 0, 30);
      test_random_phase(0, 73, 30);
      test_random_phase(26, 26, 30);

      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
